@@ design/ping_pong_stream_buffer_control_assert.svh @@
// Assertion macros used by the checker file of the ping-pong buffer control.
// Every property is sampled on clk_i and switched off while rst_ni is low.
`ifndef PING_PONG_STREAM_BUFFER_CONTROL_ASSERT_SVH
`define PING_PONG_STREAM_BUFFER_CONTROL_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define PPSB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the cycle after.
`define PPSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ppsb_pkg.sv @@
// ----------------------------------------------------------------------------
// ppsb_pkg
// Types and codes of the ping-pong stream buffer control.
// ----------------------------------------------------------------------------
package ppsb_pkg;

  localparam int unsigned FuncW  = 3;
  localparam int unsigned StateW = 4;

  // Event codes.
  localparam logic [FuncW-1:0] EV_START       = 3'd0;
  localparam logic [FuncW-1:0] EV_STOP        = 3'd1;
  localparam logic [FuncW-1:0] EV_REQUEST     = 3'd2;
  localparam logic [FuncW-1:0] EV_FILLED      = 3'd3;
  localparam logic [FuncW-1:0] EV_FIRST_DONE  = 3'd4;
  localparam logic [FuncW-1:0] EV_SECOND_DONE = 3'd5;

  // Controller states.
  localparam logic [StateW-1:0] ST_STANDBY    = 4'd0;
  localparam logic [StateW-1:0] ST_READY      = 4'd1;
  localparam logic [StateW-1:0] ST_PRIME_FILL = 4'd2;
  localparam logic [StateW-1:0] ST_PRIME_FULL = 4'd3;
  localparam logic [StateW-1:0] ST_P0_FREE1   = 4'd4;
  localparam logic [StateW-1:0] ST_P0_FILL1   = 4'd5;
  localparam logic [StateW-1:0] ST_P0_FULL1   = 4'd6;
  localparam logic [StateW-1:0] ST_P1_FREE0   = 4'd7;
  localparam logic [StateW-1:0] ST_P1_FILL0   = 4'd8;
  localparam logic [StateW-1:0] ST_P1_FULL0   = 4'd9;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             start_ok;
    logic             stop_ok;
  } in_item_t;

  typedef struct packed {
    logic              success;
    logic              grant_valid;
    logic              grant_half;
    logic              notify_owner;
    logic [StateW-1:0] current_state;
  } out_item_t;

endpackage

@@ design/ppsb_if.sv @@
// ----------------------------------------------------------------------------
// ppsb_if
// Valid/ready channels for events in and results out.
// ----------------------------------------------------------------------------
interface ppsb_in_if;
  logic               valid;
  logic               ready;
  ppsb_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppsb_out_if;
  logic                valid;
  logic                ready;
  ppsb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/ping_pong_stream_buffer_control.sv @@
// ----------------------------------------------------------------------------
// ping_pong_stream_buffer_control: event-driven ping-pong transmit buffer control.
// A result is shown in the cycle after its event transaction is accepted, from the result register.
// One event per cycle while the result channel does not stall; the next-state table and the result register set this.
// Reset: rst_ni low clears the state to standby and empties the result register.
// ----------------------------------------------------------------------------
module ping_pong_stream_buffer_control (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppsb_in_if.sink   in_i,
  ppsb_out_if.source out_o
);

  // The controller state and the one-entry result register.
  logic [ppsb_pkg::StateW-1:0] state_q, state_d;
  logic                        out_valid_q;
  ppsb_pkg::out_item_t         out_data_q, out_data_d;
  logic                        in_accept;

  // A new event is taken whenever the result register is empty or its
  // result leaves in this same cycle, so events can follow back to back.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  // Next-state table. Each event either moves the controller along the
  // ping-pong sequence or leaves the state as it is with all flags low.
  always_comb begin
    state_d                  = state_q;
    out_data_d.success       = 1'b0;
    out_data_d.grant_valid   = 1'b0;
    out_data_d.grant_half    = 1'b0;
    out_data_d.notify_owner  = 1'b0;
    unique case (in_i.data.func)
      ppsb_pkg::EV_START: begin
        // Start only counts from standby and only if the low-level start worked.
        if (state_q == ppsb_pkg::ST_STANDBY && in_i.data.start_ok) begin
          state_d                 = ppsb_pkg::ST_READY;
          out_data_d.success      = 1'b1;
          out_data_d.notify_owner = 1'b1;
        end
      end
      ppsb_pkg::EV_STOP: begin
        // Stop is honored while a half is playing; the outcome is reported as is.
        if (state_q inside {ppsb_pkg::ST_P0_FREE1, ppsb_pkg::ST_P0_FILL1,
                            ppsb_pkg::ST_P0_FULL1, ppsb_pkg::ST_P1_FREE0,
                            ppsb_pkg::ST_P1_FILL0, ppsb_pkg::ST_P1_FULL0}) begin
          state_d            = ppsb_pkg::ST_STANDBY;
          out_data_d.success = in_i.data.stop_ok;
        end
      end
      ppsb_pkg::EV_REQUEST: begin
        // The producer gets the half that is not playing, if it is free.
        if (state_q == ppsb_pkg::ST_READY) begin
          state_d                = ppsb_pkg::ST_PRIME_FILL;
          out_data_d.grant_valid = 1'b1;
          out_data_d.grant_half  = 1'b1;
        end else if (state_q == ppsb_pkg::ST_P0_FREE1) begin
          state_d                = ppsb_pkg::ST_P0_FILL1;
          out_data_d.grant_valid = 1'b1;
          out_data_d.grant_half  = 1'b1;
        end else if (state_q == ppsb_pkg::ST_P1_FREE0) begin
          state_d                = ppsb_pkg::ST_P1_FILL0;
          out_data_d.grant_valid = 1'b1;
        end
      end
      ppsb_pkg::EV_FILLED: begin
        if (state_q == ppsb_pkg::ST_P0_FILL1) begin
          state_d            = ppsb_pkg::ST_P0_FULL1;
          out_data_d.success = 1'b1;
        end else if (state_q == ppsb_pkg::ST_P1_FILL0) begin
          state_d            = ppsb_pkg::ST_P1_FULL0;
          out_data_d.success = 1'b1;
        end else if (state_q == ppsb_pkg::ST_PRIME_FILL) begin
          state_d            = ppsb_pkg::ST_PRIME_FULL;
          out_data_d.success = 1'b1;
        end
      end
      ppsb_pkg::EV_FIRST_DONE: begin
        // The engine finished the first half and moves on to the second one.
        if (state_q inside {ppsb_pkg::ST_PRIME_FILL, ppsb_pkg::ST_PRIME_FULL,
                            ppsb_pkg::ST_P0_FREE1, ppsb_pkg::ST_P0_FILL1,
                            ppsb_pkg::ST_P0_FULL1}) begin
          state_d                 = ppsb_pkg::ST_P1_FREE0;
          out_data_d.notify_owner = 1'b1;
        end
      end
      ppsb_pkg::EV_SECOND_DONE: begin
        // The engine wrapped around from the second half to the first one.
        if (state_q inside {ppsb_pkg::ST_P1_FREE0, ppsb_pkg::ST_P1_FILL0,
                            ppsb_pkg::ST_P1_FULL0}) begin
          state_d                 = ppsb_pkg::ST_P0_FREE1;
          out_data_d.notify_owner = 1'b1;
        end
      end
      default: begin
        // Undefined event codes change nothing.
      end
    endcase
    out_data_d.current_state = state_d;
  end

  // The state moves only with an accepted event transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppsb_pkg::ST_STANDBY;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

@@ design/ppsb_checker.sv @@
// ----------------------------------------------------------------------------
// ppsb_checker
// Port-level checks of the ping-pong stream buffer control.
// ----------------------------------------------------------------------------
`include "ping_pong_stream_buffer_control_assert.svh"

module ppsb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ppsb_pkg::out_item_t out_data_i
);

  // A stalled result stays put.
  `PPSB_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result changed")

  // Every accepted event shows a result in the next cycle.
  `PPSB_ASSERT_NEXT(a_in_to_out, in_valid_i && in_ready_i, out_valid_i, "event accepted but no result followed")

  // A stalled result holds back the input side.
  `PPSB_ASSERT_SAME(a_stall_back, out_valid_i && !out_ready_i, !in_ready_i, "input ready while result is stalled")

  // With the result register empty, the block always takes an event.
  `PPSB_ASSERT_SAME(a_empty_ready, !out_valid_i, in_ready_i, "input not ready with empty result register")

endmodule

bind ping_pong_stream_buffer_control ppsb_checker u_ppsb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);

@@ test/ping_pong_stream_buffer_control_tb.sv @@
// ----------------------------------------------------------------------------
// ping_pong_stream_buffer_control_tb
// Drives event transactions into the ping-pong buffer controller and checks
// every result against a cycle-free model of its ten-state next-state table.
// ----------------------------------------------------------------------------
module ping_pong_stream_buffer_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppsb_pkg::*;

  // The event field is three bits wide, so two codes carry no meaning. The
  // controller must treat them as no-ops with every flag low.
  localparam logic [FuncW-1:0] EV_SPARE_A = 3'd6;
  localparam logic [FuncW-1:0] EV_SPARE_B = 3'd7;

  localparam int unsigned NumStates    = 10;
  localparam int unsigned RandomEvents = 1680;
  localparam int unsigned CalmEvents   = 200;

  // Tracks the controller's mode and holds the results that are owed by the
  // block, oldest first. One event transaction always owes one result.
  class buffer_mode_tracker;
    logic [StateW-1:0] mode;
    out_item_t         owed_q[$];
    int unsigned       mismatches;

    function new();
      mode       = ST_STANDBY;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Works out the result of one accepted event and advances the mode.
    function void note_event(in_item_t ev);
      out_item_t res;
      res = '0;
      case (ev.func)
        EV_START: begin
          if (mode == ST_STANDBY && ev.start_ok) begin
            mode             = ST_READY;
            res.success      = 1'b1;
            res.notify_owner = 1'b1;
          end
        end
        EV_STOP: begin
          if (mode >= ST_P0_FREE1 && mode <= ST_P1_FULL0) begin
            res.success = ev.stop_ok;
            mode        = ST_STANDBY;
          end
        end
        EV_REQUEST: begin
          if (mode == ST_READY) begin
            mode            = ST_PRIME_FILL;
            res.grant_valid = 1'b1;
            res.grant_half  = 1'b1;
          end else if (mode == ST_P0_FREE1) begin
            mode            = ST_P0_FILL1;
            res.grant_valid = 1'b1;
            res.grant_half  = 1'b1;
          end else if (mode == ST_P1_FREE0) begin
            mode            = ST_P1_FILL0;
            res.grant_valid = 1'b1;
          end
        end
        EV_FILLED: begin
          if (mode == ST_P0_FILL1) begin
            mode        = ST_P0_FULL1;
            res.success = 1'b1;
          end else if (mode == ST_P1_FILL0) begin
            mode        = ST_P1_FULL0;
            res.success = 1'b1;
          end else if (mode == ST_PRIME_FILL) begin
            mode        = ST_PRIME_FULL;
            res.success = 1'b1;
          end
        end
        EV_FIRST_DONE: begin
          if (mode >= ST_PRIME_FILL && mode <= ST_P0_FULL1) begin
            mode             = ST_P1_FREE0;
            res.notify_owner = 1'b1;
          end
        end
        EV_SECOND_DONE: begin
          if (mode >= ST_P1_FREE0 && mode <= ST_P1_FULL0) begin
            mode             = ST_P0_FREE1;
            res.notify_owner = 1'b1;
          end
        end
        default: ;
      endcase
      res.current_state = mode;
      owed_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result transaction: %p", got);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      if (got.success !== want.success) begin
        $error("success: expected %0d, actual %0d", want.success, got.success);
        mismatches++;
      end
      if (got.grant_valid !== want.grant_valid) begin
        $error("grant_valid: expected %0d, actual %0d", want.grant_valid, got.grant_valid);
        mismatches++;
      end
      if (got.grant_half !== want.grant_half) begin
        $error("grant_half: expected %0d, actual %0d", want.grant_half, got.grant_half);
        mismatches++;
      end
      if (got.notify_owner !== want.notify_owner) begin
        $error("notify_owner: expected %0d, actual %0d", want.notify_owner, got.notify_owner);
        mismatches++;
      end
      if (got.current_state !== want.current_state) begin
        $error("current_state: expected %0d, actual %0d", want.current_state,
               got.current_state);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ppsb_in_if  in_if ();
  ppsb_out_if out_if ();

  ping_pong_stream_buffer_control dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  buffer_mode_tracker tracker = new();

  // Chance, in percent, that a transaction is preceded by a sender gap or that
  // the receiver starts a stall burst. The stimulus changes them per phase.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  logic        rdy_next;

  // Tallies for the closing summary.
  int unsigned event_total  = 0;
  int unsigned spare_total  = 0;
  int unsigned grant_total  = 0;
  int unsigned notify_total = 0;
  bit          state_seen [NumStates];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver side. Between stall bursts the
  // result channel is always ready. Only one assignment to ready per edge.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      rdy_next = 1'b0;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 6);
      rdy_next   = 1'b0;
    end else begin
      rdy_next = 1'b1;
    end
    out_if.ready <= rdy_next;
  end

  // Result monitor. Values are read at the edge, before any update from the
  // same edge has landed, so the check does not race the controller.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (out_if.data.grant_valid) grant_total++;
      if (out_if.data.notify_owner) notify_total++;
      if (out_if.data.current_state < NumStates) state_seen[out_if.data.current_state] = 1'b1;
      tracker.check_result(out_if.data);
    end
  end

  // Sends one event transaction and records what it owes once the controller
  // has taken it. Valid is left high on return, so back-to-back transactions
  // keep valid high unless a sender gap is drawn.
  task automatic push_event(input logic [FuncW-1:0] func, input logic start_ok,
                            input logic stop_ok);
    in_item_t ev;
    ev.func     = func;
    ev.start_ok = start_ok;
    ev.stop_ok  = stop_ok;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= ev;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    tracker.note_event(ev);
    event_total++;
    if (func == EV_SPARE_A || func == EV_SPARE_B) spare_total++;
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Picks the event that a well-behaved stream engine and producer would
  // raise next in the given mode. Stops arrive now and then while playing.
  task automatic push_plausible_event(input logic [StateW-1:0] mode);
    logic [FuncW-1:0] func;
    bit               coin;
    coin = ($urandom_range(0, 99) < 70);
    if (mode >= ST_P0_FREE1 && $urandom_range(0, 99) < 4) begin
      func = EV_STOP;
    end else begin
      case (mode)
        ST_STANDBY:    func = EV_START;
        ST_READY:      func = EV_REQUEST;
        ST_PRIME_FILL: func = coin ? EV_FILLED : EV_FIRST_DONE;
        ST_PRIME_FULL: func = EV_FIRST_DONE;
        ST_P0_FREE1:   func = coin ? EV_REQUEST : EV_FIRST_DONE;
        ST_P0_FILL1:   func = coin ? EV_FILLED : EV_FIRST_DONE;
        ST_P0_FULL1:   func = EV_FIRST_DONE;
        ST_P1_FREE0:   func = coin ? EV_REQUEST : EV_SECOND_DONE;
        ST_P1_FILL0:   func = coin ? EV_FILLED : EV_SECOND_DONE;
        default:       func = EV_SECOND_DONE;
      endcase
    end
    // A failed low-level start is kept rare so that playback gets going.
    push_event(func, ($urandom_range(0, 9) != 0), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned phase_pct [3];
    phase_pct = '{0, 15, 40};

    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk. In standby every event but a good start is ignored, as
    // are the two spare codes. Then the full ping-pong cycle runs through
    // all ten modes, including a premature first-half done while priming,
    // ignored starts and filled reports, and stops with both outcomes.
    push_event(EV_STOP,        1'b1, 1'b1);
    push_event(EV_REQUEST,     1'b1, 1'b1);
    push_event(EV_FILLED,      1'b0, 1'b0);
    push_event(EV_FIRST_DONE,  1'b1, 1'b0);
    push_event(EV_SECOND_DONE, 1'b0, 1'b1);
    push_event(EV_SPARE_A,     1'b1, 1'b1);
    push_event(EV_SPARE_B,     1'b1, 1'b1);
    push_event(EV_START,       1'b0, 1'b1);
    push_event(EV_START,       1'b1, 1'b0);
    push_event(EV_START,       1'b1, 1'b1);
    push_event(EV_STOP,        1'b0, 1'b1);
    push_event(EV_REQUEST,     1'b0, 1'b0);
    push_event(EV_FILLED,      1'b0, 1'b0);
    push_event(EV_FIRST_DONE,  1'b0, 1'b0);
    push_event(EV_REQUEST,     1'b0, 1'b0);
    push_event(EV_FILLED,      1'b0, 1'b0);
    push_event(EV_SECOND_DONE, 1'b0, 1'b0);
    push_event(EV_REQUEST,     1'b0, 1'b0);
    push_event(EV_FILLED,      1'b0, 1'b0);
    push_event(EV_FIRST_DONE,  1'b0, 1'b0);
    push_event(EV_SECOND_DONE, 1'b0, 1'b0);
    push_event(EV_STOP,        1'b1, 1'b0);
    push_event(EV_START,       1'b1, 1'b0);
    push_event(EV_REQUEST,     1'b0, 1'b0);
    push_event(EV_FIRST_DONE,  1'b0, 1'b0);
    push_event(EV_STOP,        1'b0, 1'b1);

    // The sender pauses here until the controller has handed back every
    // result, so the random part starts from a quiet channel.
    drain_results();

    // Random part in phases with their own idling mix. Mostly plausible
    // sequences so the playing modes are reached; a fifth is noise that uses
    // any event code, spare codes too, with random outcome bits.
    for (int unsigned i = 0; i < RandomEvents; i++) begin
      if (i % 280 == 0) begin
        gap_pct   = phase_pct[$urandom_range(0, 2)];
        stall_pct = phase_pct[$urandom_range(0, 2)];
      end
      if (i == RandomEvents / 2) drain_results();
      if (i == RandomEvents - CalmEvents) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      if ($urandom_range(0, 99) < 20)
        push_event(FuncW'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      else
        push_plausible_event(tracker.mode);
    end

    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    // Results come out in the cycle after their event is taken, so the closing
    // wait is enough to catch anything the controller sends uninvited.
    repeat (5) @(posedge clk_i);

    $display("Sent %0d event transactions (%0d with spare codes); %0d grants, %0d notifies.",
             event_total, spare_total, grant_total, notify_total);
    $display("Controller modes reached in results: %0d of %0d.",
             state_seen.sum() with (int'(item)), NumStates);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog. A correct run needs well under a millisecond even with the
  // longest gaps and stalls on every transaction.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/ppsb_pkg.sv
design/ppsb_if.sv
design/ping_pong_stream_buffer_control.sv
design/ppsb_checker.sv
test/ping_pong_stream_buffer_control_tb.sv
